### hw/rtl/iee_pkg.sv
`default_nettype none
package iee_pkg;
  localparam int unsigned TableSlots   = 8;
  localparam int unsigned SlotW        = $clog2(TableSlots);
  localparam int unsigned PayloadBytes = 32;

  typedef enum logic [1:0] {
    FUNC_SEND  = 2'd0,
    FUNC_BYTE  = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    OUT_NO_BUF   = 2'd0,
    OUT_SENT     = 2'd1,
    OUT_TX_FAIL  = 2'd2,
    OUT_REFUSED  = 2'd3
  } outcome_t;

  typedef enum logic [2:0] {
    KIND_SENT     = 3'd0,
    KIND_FAILED   = 3'd1,
    KIND_QUERY    = 3'd2,
    KIND_SHORT    = 3'd3,
    KIND_BAD_SUM  = 3'd4,
    KIND_REPLY    = 3'd5,
    KIND_REQUEST  = 3'd6,
    KIND_UNKNOWN  = 3'd7
  } kind_t;

  localparam logic [7:0]  IcmpEchoRequest = 8'd8;
  localparam logic [7:0]  IcmpEchoReply   = 8'd0;
  localparam logic [15:0] IcmpHdrLen      = 16'd8;
  localparam logic [15:0] TypeAdjust      = 16'h0800;

  // One's complement add with end-around carry.
  function automatic logic [15:0] add_fold(input logic [15:0] s, input logic [15:0] w);
    logic [16:0] t;
    t = {1'b0, s} + {1'b0, w};
    return t[15:0] + {15'd0, t[16]};
  endfunction

  // Uncomplemented one's complement sum of the fixed request fields and payload; the id is added later.
  function automatic logic [15:0] base_sum();
    logic [15:0] s;
    logic [7:0]  hi;
    logic [7:0]  lo;
    s = 16'd0;
    s = add_fold(s, {IcmpEchoRequest, 8'd0});
    s = add_fold(s, 16'd1);
    for (int i = 0; i < PayloadBytes; i += 2) begin
      hi = 8'(97 + (i % 26));
      lo = (i + 1 < PayloadBytes) ? 8'(97 + ((i + 1) % 26)) : 8'd0;
      s = add_fold(s, {hi, lo});
    end
    return s;
  endfunction

  localparam logic [15:0] ReqBaseSum = base_sum();

  typedef struct packed {
    logic send;
    logic query;
    logic rx_byte;
    logic load_out;
  } iee_cmd_t;

  typedef struct packed {
    logic out_full;
  } iee_sts_t;
endpackage
`default_nettype wire

### hw/rtl/icmp_echo_engine.sv
`default_nettype none
// Channel | Dir | Ports  | Payload
// in      | in  | in_t*  | tdata data_byte..query_id, tuser func, tlast last byte
// out     | out | out_t* | tdata echo_id..rtt_ns, tuser kind
// Each request is executed in the cycle it is accepted; a result, if it yields one,
// is registered at that same edge and offered from the following cycle.
// Sustained rate is one request per cycle while the output is drained each cycle.
// The output register holds a result until taken; input stalls only while it is full.
// Synchronous active-low reset empties the slot table and the receive state.
module icmp_echo_engine
  import iee_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [7:0] data_byte, [71:8] now_ns, [103:72] dst_addr, [105:104] send_outcome,
  // [121:106] query_id, [127:122] zero
  input  wire logic [127:0] in_tdata,
  // [1:0] func
  input  wire logic [1:0]   in_tuser,
  input  wire logic         in_tlast,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [15:0] echo_id, [31:16] checksum_out, [32] answered, [96:33] rtt_ns, [103:97] zero
  output logic [103:0]      out_tdata,
  // [2:0] kind
  output logic [2:0]        out_tuser
);
  iee_cmd_t cmd;
  iee_sts_t sts;
  logic [15:0] echo_id, ck;
  logic        ans;
  logic [63:0] rtt;

  iee_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid,
    .in_fire(in_tvalid && in_tready),
    .in_func(in_tuser), .in_last(in_tlast),
    .sts, .in_tready, .cmd
  );

  iee_datapath u_dp (
    .clk, .rst_n, .cmd,
    .data_byte(in_tdata[7:0]), .last(in_tlast), .now_ns(in_tdata[71:8]),
    .dst_addr(in_tdata[103:72]), .send_outcome(in_tdata[105:104]),
    .query_id(in_tdata[121:106]), .out_tready, .sts, .out_tvalid,
    .kind(out_tuser), .echo_id, .checksum_out(ck), .answered(ans), .rtt_ns(rtt)
  );

  assign out_tdata = {7'd0, rtt, ans, ck, echo_id};

  logic unused_t;
  assign unused_t = ^in_tdata[127:122];

  a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready) else $error("accepted while full");
  a_send_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == FUNC_SEND) |=> out_tvalid)
    else $error("send gave no result");
  a_sent_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_SENT) |-> (out_tdata[15:0] != 16'd0))
    else $error("zero id sent");
endmodule
`default_nettype wire

### hw/rtl/iee_ctrl.sv
`default_nettype none
module iee_ctrl
  import iee_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  input  wire logic     in_fire,
  input  wire logic [1:0] in_func,
  input  wire logic     in_last,
  input  iee_sts_t      sts,
  output logic          in_tready,
  output iee_cmd_t      cmd
);
  typedef enum logic [1:0] {
    ST_RUN  = 2'b01,
    ST_HOLD = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // An item is taken whenever the output register is free or being drained.
  assign in_tready = (state_r == ST_RUN) && !sts.out_full;

  always_comb begin
    cmd = '0;
    cmd.send     = in_fire && (in_func == FUNC_SEND);
    cmd.rx_byte  = in_fire && (in_func == FUNC_BYTE);
    cmd.query    = in_fire && (in_func == FUNC_QUERY);
    cmd.load_out = cmd.send || cmd.query || (cmd.rx_byte && in_last);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_RUN:  state_nxt = ST_RUN;
      ST_HOLD: state_nxt = ST_RUN;
      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  logic unused_v;
  assign unused_v = in_tvalid;
endmodule
`default_nettype wire

### hw/rtl/iee_datapath.sv
`default_nettype none
module iee_datapath
  import iee_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  iee_cmd_t         cmd,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last,
  input  wire logic [63:0] now_ns,
  input  wire logic [31:0] dst_addr,
  input  wire logic [1:0]  send_outcome,
  input  wire logic [15:0] query_id,
  input  wire logic        out_tready,
  output iee_sts_t         sts,
  output logic             out_tvalid,
  output logic [2:0]       kind,
  output logic [15:0]      echo_id,
  output logic [15:0]      checksum_out,
  output logic             answered,
  output logic [63:0]      rtt_ns
);
  logic [15:0] slot_id_r    [TableSlots];
  logic [31:0] slot_dest_r  [TableSlots];
  logic [63:0] slot_sent_r  [TableSlots];
  logic [63:0] slot_reply_r [TableSlots];
  logic [TableSlots-1:0] slot_used_r, slot_ans_r;
  logic [15:0] next_id_r;
  logic [15:0] rx_cnt_r;
  logic [15:0] rx_sum_r;
  logic [7:0]  rx_type_r, rx_odd_r;
  logic [15:0] rx_ident_r, rx_ck_r;
  logic        valid_r;
  logic [2:0]  kind_r;
  logic [15:0] id_r, ck_r;
  logic        ans_r;
  logic [63:0] rtt_r;

  // Slot choice: first free, else oldest (lowest index on ties).
  // A slot is the oldest when it is strictly older than every lower slot and
  // no younger than every higher one, so all compares run side by side.
  logic [SlotW-1:0] free_idx, old_idx, pick;
  logic             free_any;
  logic [TableSlots-1:0] is_old;
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = TableSlots - 1; i >= 0; i--) begin
      if (!slot_used_r[i]) begin
        free_idx = SlotW'(i);
        free_any = 1'b1;
      end
    end
    for (int i = 0; i < TableSlots; i++) begin
      is_old[i] = 1'b1;
      for (int j = 0; j < TableSlots; j++) begin
        if (j < i && !(slot_sent_r[i] < slot_sent_r[j])) is_old[i] = 1'b0;
        if (j > i && (slot_sent_r[j] < slot_sent_r[i])) is_old[i] = 1'b0;
      end
    end
    old_idx = '0;
    for (int i = TableSlots - 1; i >= 0; i--) begin
      if (is_old[i]) old_idx = SlotW'(i);
    end
    pick = free_any ? free_idx : old_idx;
  end

  // Lowest used slot matching an id.
  function automatic logic [SlotW:0] match(input logic [15:0] id,
      input logic [TableSlots-1:0] used, input logic [15:0] ids [TableSlots]);
    logic [SlotW:0] r;
    r = '0;
    for (int i = TableSlots - 1; i >= 0; i--) begin
      if (used[i] && ids[i] == id) r = {1'b1, SlotW'(i)};
    end
    return r;
  endfunction

  // Receive byte path.
  logic [15:0] cnt_nxt, sum_b, sum_f, ident_b;
  logic [7:0]  type_b, odd_b;
  logic [15:0] ck_b;

  always_comb begin
    type_b  = rx_type_r;
    ck_b    = rx_ck_r;
    ident_b = rx_ident_r;
    odd_b   = rx_odd_r;
    sum_b   = rx_sum_r;
    if (rx_cnt_r == 16'd0) type_b = data_byte;
    if (rx_cnt_r == 16'd2) ck_b[15:8] = data_byte;
    if (rx_cnt_r == 16'd3) ck_b[7:0] = data_byte;
    if (rx_cnt_r == 16'd4) ident_b[15:8] = data_byte;
    if (rx_cnt_r == 16'd5) ident_b[7:0] = data_byte;
    if (!rx_cnt_r[0]) odd_b = data_byte;
    else sum_b = add_fold(rx_sum_r, {rx_odd_r, data_byte});
    cnt_nxt = (rx_cnt_r == 16'hFFFF) ? 16'hFFFE : rx_cnt_r + 16'd1;
    sum_f = cnt_nxt[0] ? add_fold(sum_b, {odd_b, 8'd0}) : sum_b;
  end

  logic [SlotW:0] q_hit, r_hit;
  assign q_hit = match(query_id, slot_used_r, slot_id_r);
  assign r_hit = match(ident_b, slot_used_r, slot_id_r);

  logic [15:0] adj_a;
  always_comb begin
    adj_a = ~ck_b;
    if (adj_a < TypeAdjust) adj_a = adj_a + 16'hFFFF;
    adj_a = adj_a - TypeAdjust;
  end

  logic [15:0] id_inc;
  assign id_inc = (next_id_r == 16'hFFFF) ? 16'd1 : next_id_r + 16'd1;

  assign sts.out_full = valid_r && !out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TableSlots; i++) begin
        slot_id_r[i] <= '0; slot_dest_r[i] <= '0;
        slot_sent_r[i] <= '0; slot_reply_r[i] <= '0;
      end
      slot_used_r <= '0; slot_ans_r <= '0;
      next_id_r <= 16'd1;
      rx_cnt_r <= '0; rx_sum_r <= '0; rx_type_r <= '0;
      rx_odd_r <= '0; rx_ident_r <= '0; rx_ck_r <= '0;
      valid_r <= 1'b0;
    end else begin
      if (valid_r && out_tready) valid_r <= 1'b0;
      if (cmd.load_out) valid_r <= 1'b1;
      if (cmd.send) begin
        kind_r <= KIND_FAILED; id_r <= '0; ck_r <= '0; ans_r <= 1'b0; rtt_r <= '0;
        if (send_outcome != OUT_NO_BUF) next_id_r <= id_inc;
        if (send_outcome == OUT_SENT || send_outcome == OUT_TX_FAIL) begin
          slot_id_r[pick] <= next_id_r;
          slot_dest_r[pick] <= dst_addr;
          slot_sent_r[pick] <= now_ns;
          slot_reply_r[pick] <= '0;
          slot_ans_r[pick] <= 1'b0;
          slot_used_r[pick] <= (send_outcome == OUT_SENT);
        end
        if (send_outcome == OUT_SENT) begin
          kind_r <= KIND_SENT; id_r <= next_id_r;
          ck_r <= ~add_fold(ReqBaseSum, next_id_r);
        end
      end
      if (cmd.query) begin
        kind_r <= KIND_QUERY; id_r <= query_id; ck_r <= '0;
        ans_r <= 1'b0; rtt_r <= '0;
        if (q_hit[SlotW] && slot_ans_r[q_hit[SlotW-1:0]]) begin
          ans_r <= 1'b1;
          rtt_r <= slot_reply_r[q_hit[SlotW-1:0]] - slot_sent_r[q_hit[SlotW-1:0]];
        end
      end
      if (cmd.rx_byte) begin
        if (!last) begin
          rx_cnt_r <= cnt_nxt; rx_sum_r <= sum_b; rx_type_r <= type_b;
          rx_odd_r <= odd_b; rx_ident_r <= ident_b; rx_ck_r <= ck_b;
        end else begin
          rx_cnt_r <= '0; rx_sum_r <= '0; rx_type_r <= '0;
          rx_odd_r <= '0; rx_ident_r <= '0; rx_ck_r <= '0;
          id_r <= ident_b; ck_r <= '0; ans_r <= 1'b0; rtt_r <= '0;
          if (cnt_nxt < IcmpHdrLen) begin
            kind_r <= KIND_SHORT; id_r <= '0;
          end else if (sum_f != 16'hFFFF) begin
            kind_r <= KIND_BAD_SUM;
          end else if (type_b == IcmpEchoReply) begin
            kind_r <= KIND_REPLY;
            ans_r <= r_hit[SlotW];
            if (r_hit[SlotW]) begin
              slot_ans_r[r_hit[SlotW-1:0]] <= 1'b1;
              slot_reply_r[r_hit[SlotW-1:0]] <= now_ns;
            end
          end else if (type_b == IcmpEchoRequest) begin
            kind_r <= KIND_REQUEST; ck_r <= ~adj_a;
          end else begin
            kind_r <= KIND_UNKNOWN;
          end
        end
      end
    end
  end

  assign out_tvalid   = valid_r;
  assign kind         = kind_r;
  assign echo_id      = id_r;
  assign checksum_out = ck_r;
  assign answered     = ans_r;
  assign rtt_ns       = rtt_r;

  logic unused_d;
  always_comb begin
    unused_d = 1'b0;
    for (int i = 0; i < TableSlots; i++) unused_d = unused_d ^ ^slot_dest_r[i];
  end
endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import iee_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] echo_id;
    logic [15:0] cksum;
    logic        answered;
    logic [63:0] rtt;
  } echo_res_t;

  typedef struct {
    func_t       func;
    logic [7:0]  data;
    logic        last;
    logic [63:0] now;
    logic [31:0] dst;
    outcome_t    outcome;
    logic [15:0] qid;
    logic        has_exp;
    echo_res_t   exp;
  } echo_req_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, in_tlast, out_tvalid, out_tready;
  logic [127:0] in_tdata;
  logic [1:0]   in_tuser;
  logic [103:0] out_tdata;
  logic [2:0]   out_tuser;

  icmp_echo_engine u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // Predictor state.
  logic [15:0] p_id [TableSlots];
  logic [63:0] p_sent [TableSlots];
  logic [63:0] p_reply [TableSlots];
  logic        p_used [TableSlots];
  logic        p_ans [TableSlots];
  logic [15:0] p_next_id, p_count, p_ident, p_ckfield;
  logic [15:0] p_sum;
  logic [7:0]  p_type, p_odd;

  echo_res_t expected_q[$];
  echo_req_t directed[$];
  int errors, mismatches, results_seen, cycles;
  bit quiet, hold_off, stim_done;
  int n_sent, n_reply, n_req, n_query;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("timeout after %0d cycles", cycles);
      $display("icmp_echo_engine: mismatch");
      $finish;
    end
  end

  function automatic logic [15:0] fold_add(logic [15:0] s, logic [15:0] w);
    logic [16:0] t;
    t = {1'b0, s} + {1'b0, w};
    return t[15:0] + {15'd0, t[16]};
  endfunction

  function automatic logic [15:0] ping_checksum(logic [15:0] id);
    logic [15:0] s;
    s = fold_add(16'd0, {IcmpEchoRequest, 8'd0});
    s = fold_add(s, id);
    s = fold_add(s, 16'd1);
    for (int i = 0; i < PayloadBytes; i += 2)
      s = fold_add(s, {8'(97 + (i % 26)),
                       (i + 1 < PayloadBytes) ? 8'(97 + ((i + 1) % 26)) : 8'd0});
    return ~s;
  endfunction

  function automatic void clear_rx();
    p_count = '0; p_sum = '0; p_type = '0; p_ident = '0; p_ckfield = '0; p_odd = '0;
  endfunction

  // Returns 1 when the request yields a result, written to r.
  function automatic bit predict_echo(echo_req_t q, output echo_res_t r);
    int pick;
    bit found;
    logic [15:0] n, id;
    logic [16:0] a;
    r = '0;
    case (q.func)
      FUNC_SEND: begin
        pick = 0; found = 0;
        for (int i = 0; i < TableSlots; i++)
          if (!found && !p_used[i]) begin pick = i; found = 1; end
        if (!found)
          for (int i = 1; i < TableSlots; i++)
            if (p_sent[i] < p_sent[pick]) pick = i;
        r.kind = KIND_FAILED;
        if (q.outcome == OUT_NO_BUF) return 1;
        id = p_next_id;
        p_next_id = p_next_id + 16'd1;
        if (p_next_id == 16'd0) p_next_id = 16'd1;
        if (q.outcome == OUT_REFUSED) return 1;
        p_id[pick] = id; p_sent[pick] = q.now; p_reply[pick] = '0; p_ans[pick] = 1'b0;
        p_used[pick] = (q.outcome == OUT_SENT);
        if (q.outcome == OUT_SENT) begin
          r.kind = KIND_SENT; r.echo_id = id; r.cksum = ping_checksum(id);
        end
        return 1;
      end
      FUNC_QUERY: begin
        r.kind = KIND_QUERY; r.echo_id = q.qid;
        for (int i = 0; i < TableSlots; i++)
          if (p_used[i] && p_id[i] == q.qid) begin
            if (p_ans[i]) begin r.answered = 1; r.rtt = p_reply[i] - p_sent[i]; end
            return 1;
          end
        return 1;
      end
      FUNC_BYTE: begin
        n = p_count;
        if (n == 0) p_type = q.data;
        else if (n == 2) p_ckfield[15:8] = q.data;
        else if (n == 3) p_ckfield[7:0] = q.data;
        else if (n == 4) p_ident[15:8] = q.data;
        else if (n == 5) p_ident[7:0] = q.data;
        if (!n[0]) p_odd = q.data;
        else p_sum = fold_add(p_sum, {p_odd, q.data});
        p_count = (n == 16'hFFFF) ? 16'hFFFE : n + 16'd1;
        if (!q.last) return 0;
        if (p_count[0]) p_sum = fold_add(p_sum, {p_odd, 8'd0});
        if (p_count < IcmpHdrLen) r.kind = KIND_SHORT;
        else if (p_sum != 16'hFFFF) begin r.kind = KIND_BAD_SUM; r.echo_id = p_ident; end
        else if (p_type == IcmpEchoReply) begin
          r.kind = KIND_REPLY; r.echo_id = p_ident; found = 0;
          for (int i = 0; i < TableSlots; i++)
            if (!found && p_used[i] && p_id[i] == p_ident) begin
              p_ans[i] = 1; p_reply[i] = q.now; found = 1;
            end
          r.answered = found;
        end else if (p_type == IcmpEchoRequest) begin
          a = {1'b0, ~p_ckfield};
          if (a < TypeAdjust) a = a + 17'hFFFF;
          a = a - TypeAdjust;
          r.kind = KIND_REQUEST; r.echo_id = p_ident; r.cksum = ~a[15:0];
        end else begin
          r.kind = KIND_UNKNOWN; r.echo_id = p_ident;
        end
        clear_rx();
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  // Hand one request to the block, waiting for acceptance.
  task automatic send_request(echo_req_t q);
    echo_res_t r;
    while (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= q.func;
    in_tlast  <= q.last;
    in_tdata  <= {6'd0, q.qid, q.outcome, q.dst, q.now, q.data};
    do @(posedge clk); while (!in_tready);
    if (predict_echo(q, r)) begin
      if (q.has_exp && r !== q.exp) begin
        errors++;
        $display("directed row disagrees with predictor: %h vs %h", q.exp, r);
      end
      expected_q.push_back(r);
      case (r.kind)
        KIND_SENT: n_sent++;
        KIND_REPLY: n_reply++;
        KIND_REQUEST: n_req++;
        KIND_QUERY: n_query++;
        default: ;
      endcase
    end
  endtask

  function automatic echo_req_t mk(func_t f, logic [7:0] d, logic l, logic [63:0] t,
                                   outcome_t o, logic [15:0] qid);
    echo_req_t q;
    q.func = f; q.data = d; q.last = l; q.now = t; q.dst = $urandom;
    q.outcome = o; q.qid = qid; q.has_exp = 0; q.exp = '0;
    return q;
  endfunction

  // Pushes a message of the given type and id with random payload, checksum valid unless corrupt.
  task automatic send_message(logic [7:0] typ, logic [15:0] id, int len, bit corrupt,
                              logic [63:0] t);
    logic [7:0] b [];
    logic [15:0] s;
    b = new[len];
    foreach (b[i]) b[i] = 8'($urandom);
    b[0] = typ; b[2] = 8'd0; b[3] = 8'd0;
    if (len > 5) begin b[4] = id[15:8]; b[5] = id[7:0]; end
    s = '0;
    for (int i = 0; i < len; i += 2)
      s = fold_add(s, {b[i], (i + 1 < len) ? b[i + 1] : 8'd0});
    if (len > 3) begin b[2] = ~s[15:8]; b[3] = ~s[7:0]; end
    if (corrupt) b[len - 1] = b[len - 1] ^ 8'h01;
    for (int i = 0; i < len; i++) begin
      send_request(mk(FUNC_BYTE, b[i], i == len - 1, t, OUT_SENT, 16'd0));
      if ($urandom_range(0, 15) == 0)
        send_request(mk(FUNC_QUERY, 8'd0, 1'b0, t, OUT_SENT, 16'($urandom_range(0, 12))));
    end
  endtask

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      echo_res_t got, want;
      got = {out_tuser, out_tdata[15:0], out_tdata[31:16], out_tdata[32], out_tdata[96:33]};
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          errors++;
          if (mismatches++ < 10)
            $display("result %0d: kind %0d/%0d id %h/%h ck %h/%h ans %b/%b rtt %h/%h",
                     results_seen, want.kind, got.kind, want.echo_id, got.echo_id,
                     want.cksum, got.cksum, want.answered, got.answered,
                     want.rtt, got.rtt);
        end
      end
    end
  end

  // Receiver: random stalls, one long hold-off, none once quiet.
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_off = 0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    logic [63:0] t;
    echo_req_t q;
    int k, drain;
    errors = 0; mismatches = 0; results_seen = 0; cycles = 0;
    quiet = 0; hold_off = 0;
    n_sent = 0; n_reply = 0; n_req = 0; n_query = 0;
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; in_tuser = FUNC_NONE; in_tlast = 1'b0;
    foreach (p_id[i]) begin
      p_id[i] = '0; p_sent[i] = '0; p_reply[i] = '0; p_used[i] = 1'b0; p_ans[i] = 1'b0;
    end
    p_next_id = 16'd1;
    clear_rx();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    q = mk(FUNC_QUERY, 8'd0, 1'b0, 64'd0, OUT_SENT, 16'd0);
    q.has_exp = 1; q.exp = '{KIND_QUERY, 16'd0, 16'd0, 1'b0, 64'd0}; directed.push_back(q);
    q = mk(FUNC_SEND, 8'd0, 1'b0, 64'd0, OUT_NO_BUF, 16'd0);
    q.has_exp = 1; q.exp = '{KIND_FAILED, 16'd0, 16'd0, 1'b0, 64'd0}; directed.push_back(q);
    q = mk(FUNC_SEND, 8'd0, 1'b0, 64'd100, OUT_SENT, 16'd0);
    q.has_exp = 1; q.exp = '{KIND_SENT, 16'd1, ping_checksum(16'd1), 1'b0, 64'd0};
    directed.push_back(q);
    q = mk(FUNC_SEND, 8'd0, 1'b0, 64'd5, OUT_REFUSED, 16'hFFFF);
    q.has_exp = 1; q.exp = '{KIND_FAILED, 16'd0, 16'd0, 1'b0, 64'd0}; directed.push_back(q);
    q = mk(FUNC_SEND, 8'd0, 1'b0, 64'd7, OUT_TX_FAIL, 16'd0);
    q.has_exp = 1; q.exp = '{KIND_FAILED, 16'd0, 16'd0, 1'b0, 64'd0}; directed.push_back(q);
    q = mk(FUNC_SEND, 8'd0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, OUT_SENT, 16'd0);
    directed.push_back(q);
    q = mk(FUNC_SEND, 8'd0, 1'b0, 64'd0, OUT_SENT, 16'd0); directed.push_back(q);
    q = mk(FUNC_NONE, 8'hFF, 1'b1, 64'd1, OUT_SENT, 16'hFFFF); directed.push_back(q);
    q = mk(FUNC_BYTE, 8'hFF, 1'b1, 64'd0, OUT_SENT, 16'd0);
    q.has_exp = 1; q.exp = '{KIND_SHORT, 16'd0, 16'd0, 1'b0, 64'd0}; directed.push_back(q);
    q = mk(FUNC_QUERY, 8'd0, 1'b0, 64'd0, OUT_SENT, 16'd1); directed.push_back(q);
    q = mk(FUNC_QUERY, 8'd0, 1'b0, 64'd0, OUT_SENT, 16'hFFFF); directed.push_back(q);
    foreach (directed[i]) send_request(directed[i]);
    send_message(IcmpEchoReply, 16'd1, 8, 0, 64'd350);
    send_message(IcmpEchoReply, 16'd1, 9, 0, 64'd20);
    send_message(IcmpEchoRequest, 16'hFFFF, 8, 0, 64'd0);
    send_message(IcmpEchoRequest, 16'h0000, 41, 0, 64'd0);
    send_message(8'hFF, 16'h1234, 10, 0, 64'd0);
    send_message(IcmpEchoReply, 16'd2, 8, 1, 64'd0);
    send_request(mk(FUNC_QUERY, 8'd0, 1'b0, 64'd0, OUT_SENT, 16'd1));
    // An all-zero message sums to 0x0000, not 0xFFFF, so it is bad.
    for (int i = 0; i < 8; i++)
      send_request(mk(FUNC_BYTE, 8'h00, i == 7, 64'd0, OUT_SENT, 16'd0));

    // Random part: mostly pings with matching replies, with some noise.
    t = 64'd1000;
    fork
      begin
        repeat (100) @(posedge clk);
        hold_off = 1;
      end
    join_none
    k = 0;
    while (k < 800) begin
      t = t + 64'($urandom_range(1, 5000));
      if (k > 650) quiet = 1;
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          q = mk(FUNC_SEND, 8'd0, 1'b0,
                 ($urandom_range(0, 15) == 0) ? {$urandom, $urandom} : t,
                 outcome_t'($urandom_range(0, 6) < 5 ? OUT_SENT : $urandom_range(0, 3)),
                 16'd0);
          send_request(q);
          k++;
        end
        3, 4, 5: begin
          send_message($urandom_range(0, 3) == 0 ? IcmpEchoRequest : IcmpEchoReply,
                       16'(p_next_id - 16'($urandom_range(1, 10))), $urandom_range(8, 16),
                       $urandom_range(0, 7) == 0, t);
          k += 10;
        end
        6, 7: begin
          send_request(mk(FUNC_QUERY, 8'd0, 1'b0, t, OUT_SENT,
                          $urandom_range(0, 3) == 0 ? 16'($urandom)
                                                    : 16'(p_next_id - 16'($urandom_range(1, 10)))));
          k++;
        end
        8: begin
          send_request(mk(FUNC_BYTE, 8'($urandom), $urandom_range(0, 3) == 0, t,
                          OUT_SENT, 16'd0));
          k++;
        end
        default: begin
          q = mk(func_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
                 {$urandom, $urandom}, outcome_t'($urandom_range(0, 3)), 16'($urandom));
          send_request(q);
          k++;
        end
      endcase
    end
    // Close any partial message so the receive state ends clean.
    send_request(mk(FUNC_BYTE, 8'h00, 1'b1, t, OUT_SENT, 16'd0));
    in_tvalid <= 1'b0;
    quiet = 1;
    drain = 0;
    while (expected_q.size() != 0 && drain < 10000) begin
      @(posedge clk);
      drain++;
    end
    repeat (5) @(posedge clk);
    $display("checked %0d results: %0d pings sent, %0d replies, %0d requests answered,",
             results_seen, n_sent, n_reply, n_req);
    $display("%0d queries, plus short, corrupt, unknown and odd-length messages",
             n_query);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("icmp_echo_engine: match");
    end else begin
      $display("%0d errors, %0d results still outstanding", errors, expected_q.size());
      $display("icmp_echo_engine: mismatch");
    end
    $finish;
  end
endmodule

### icmp_echo_engine.f
hw/rtl/iee_pkg.sv
hw/rtl/iee_ctrl.sv
hw/rtl/iee_datapath.sv
hw/rtl/icmp_echo_engine.sv
tb/testbench.sv
